// File: design/atkd_pkg.sv
package atkd_pkg;

  localparam int unsigned MAX_FRAME_ROWS = 1024;
  localparam int unsigned ROW_W          = 10;
  localparam int unsigned CFG_INDEX_W    = 2;
  localparam int unsigned CFG_DATA_W     = 11;
  localparam int unsigned ERR_SHIFT      = 3;

  localparam logic [7:0]  THRESHOLD_RST   = 8'd64;
  localparam logic [6:0]  WHITE_LEVEL_RST = 7'd127;
  localparam logic [9:0]  LINE_WIDTH_RST  = 10'd400;
  localparam logic [10:0] FRAME_ROWS_RST  = 11'd240;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_WHITE_LEVEL = 2'd1,
    CFG_LINE_WIDTH  = 2'd2,
    CFG_FRAME_ROWS  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  threshold;
    logic [6:0]  white_level;
    logic [9:0]  line_width;
    logic [10:0] frame_rows;
  } cfg_t;

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic last_row;
    logic col_room;
    logic row_room;
  } pos_t;

endpackage

// File: design/atkd_cfg.sv
module atkd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [atkd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [atkd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output atkd_pkg::cfg_t                    cfg
);

  atkd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold   <= atkd_pkg::THRESHOLD_RST;
      cfg_r.white_level <= atkd_pkg::WHITE_LEVEL_RST;
      cfg_r.line_width  <= atkd_pkg::LINE_WIDTH_RST;
      cfg_r.frame_rows  <= atkd_pkg::FRAME_ROWS_RST;
    end else if (cfg_valid) begin
      unique case (atkd_pkg::cfg_reg_t'(cfg_index))
        atkd_pkg::CFG_THRESHOLD:   cfg_r.threshold   <= cfg_data[7:0];
        atkd_pkg::CFG_WHITE_LEVEL: cfg_r.white_level <= cfg_data[6:0];
        atkd_pkg::CFG_LINE_WIDTH:  cfg_r.line_width  <= cfg_data[9:0];
        atkd_pkg::CFG_FRAME_ROWS:  cfg_r.frame_rows  <= cfg_data[10:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

endmodule

// File: design/atkd_pos.sv
module atkd_pos #(
  parameter int unsigned MAX_LINE_WIDTH = 512,
  parameter int unsigned AW             = 9
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            advance,
  input  atkd_pkg::cfg_t  cfg,
  output logic [AW-1:0]   col,
  output atkd_pkg::pos_t  pos
);

  localparam int unsigned WMAX = (MAX_LINE_WIDTH < 1023) ? MAX_LINE_WIDTH : 1023;
  localparam int unsigned CMPW = ((AW > 10) ? AW : 10) + 1;
  localparam int unsigned RXW  = atkd_pkg::ROW_W + 2;

  logic [AW-1:0]                col_r, col_nxt;
  logic [atkd_pkg::ROW_W-1:0]   row_r, row_nxt;
  logic [9:0]                   w_eff;
  logic [10:0]                  h_eff;
  logic [CMPW-1:0]              w_x, cnt_x, c_x, c_inc;
  logic [RXW-1:0]               h_x, rcnt_x, r_x, r_inc;

  always_comb begin
    if (cfg.line_width == '0) begin
      w_eff = 10'd1;
    end else if (cfg.line_width > 10'(WMAX)) begin
      w_eff = 10'(WMAX);
    end else begin
      w_eff = cfg.line_width;
    end
    if (cfg.frame_rows == '0) begin
      h_eff = 11'd1;
    end else if (cfg.frame_rows > 11'(atkd_pkg::MAX_FRAME_ROWS)) begin
      h_eff = 11'(atkd_pkg::MAX_FRAME_ROWS);
    end else begin
      h_eff = cfg.frame_rows;
    end

    w_x    = CMPW'(w_eff);
    cnt_x  = CMPW'(col_r);
    c_x    = (cnt_x >= w_x) ? (w_x - CMPW'(1)) : cnt_x;
    c_inc  = c_x + CMPW'(1);
    h_x    = RXW'(h_eff);
    rcnt_x = RXW'(row_r);
    r_x    = (rcnt_x >= h_x) ? (h_x - RXW'(1)) : rcnt_x;
    r_inc  = r_x + RXW'(1);

    pos.first_col = (c_x == '0);
    pos.last_col  = (c_inc >= w_x);
    pos.col_room  = ((c_x + CMPW'(2)) < w_x);
    pos.last_row  = (r_inc >= h_x);
    pos.row_room  = ((r_x + RXW'(2)) < h_x);
    col           = c_x[AW-1:0];

    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (pos.last_col) begin
        col_nxt = '0;
        row_nxt = pos.last_row ? '0 : r_inc[atkd_pkg::ROW_W-1:0];
      end else begin
        col_nxt = c_inc[AW-1:0];
        row_nxt = r_x[atkd_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// File: design/atkd_errmem.sv
module atkd_errmem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9,
  parameter int unsigned EW    = 10
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] rd_addr_m,
  input  logic          rb_we,
  input  logic [AW-1:0] rb_wa,
  input  logic [EW-1:0] rb_wd,
  input  logic          tb_we,
  input  logic [AW-1:0] tb_wa,
  input  logic [EW-1:0] tb_wd,
  output logic [EW-1:0] rbc_q,
  output logic [EW-1:0] rbm_q,
  output logic [EW-1:0] tbc_q
);

  logic [EW-1:0] rb_mem [DEPTH];
  logic [EW-1:0] tb_mem [DEPTH];

  logic          clr_r;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          clr_nxt;

  logic          rb_we_i, tb_we_i;
  logic [AW-1:0] rb_wa_i, tb_wa_i;
  logic [EW-1:0] rb_wd_i, tb_wd_i;
  logic [EW-1:0] rbc_q_r, rbm_q_r, tbc_q_r;

  always_comb begin
    rb_we_i = clr_r | rb_we;
    rb_wa_i = clr_r ? clr_addr_r : rb_wa;
    rb_wd_i = clr_r ? '0 : rb_wd;
    tb_we_i = clr_r | tb_we;
    tb_wa_i = clr_r ? clr_addr_r : tb_wa;
    tb_wd_i = clr_r ? '0 : tb_wd;

    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rb_we_i) begin
      rb_mem[rb_wa_i] <= rb_wd_i;
    end
    if (tb_we_i) begin
      tb_mem[tb_wa_i] <= tb_wd_i;
    end
  end

  // write-first: a read at the edge of a write to the same entry sees the new data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rbc_q_r <= (rb_we_i && rb_wa_i == rd_addr)   ? rb_wd_i : rb_mem[rd_addr];
      rbm_q_r <= (rb_we_i && rb_wa_i == rd_addr_m) ? rb_wd_i : rb_mem[rd_addr_m];
      tbc_q_r <= (tb_we_i && tb_wa_i == rd_addr)   ? tb_wd_i : tb_mem[rd_addr];
    end
  end

  assign busy  = clr_r;
  assign rbc_q = rbc_q_r;
  assign rbm_q = rbm_q_r;
  assign tbc_q = tbc_q_r;

endmodule

// File: design/atkinson_error_diffusion_dither_top.sv
// Atkinson error-diffusion dither: one signed grey pixel per item in raster order, one
// black/white bit per item out, with a frame_end flag on the last pixel of the frame.
// Sustained rate is one item per clock while out_stall is low and no clear runs; each
// item is registered in the compute stage, then its result in the output register. The
// error carried to the next pixel closes inside the single compute stage that follows
// the row-error memory read, which sets that rate. Per-column errors for the next two
// rows live in two MAX_LINE_WIDTH-deep memories; after reset a clearing pass zeroes
// them, with in_stall held high. Configuration writes are always taken (cfg_ready is
// tied high) and must only be issued while the block is idle.
module atkinson_error_diffusion_dither_top #(
  parameter int unsigned MAX_LINE_WIDTH = 512,
  parameter int unsigned ERROR_WIDTH    = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [7:0]                in_pixel_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_pixel_on,
  output logic                             out_frame_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [atkd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [atkd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned AW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned EW = ERROR_WIDTH;

  function automatic logic [EW-1:0] sat_add(input logic [EW-1:0] a, input logic [EW-1:0] b);
    logic [EW:0] s;
    s = {a[EW-1], a} + {b[EW-1], b};
    if (s[EW] != s[EW-1]) begin
      return s[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end
    return s[EW-1:0];
  endfunction

  atkd_pkg::cfg_t cfg;
  atkd_pkg::pos_t pos_f;
  logic [AW-1:0]  pos_col;
  logic           busy;
  logic           in_take;
  logic           go;

  logic           s1_valid_r, s1_valid_nxt;
  logic [7:0]     s1_pix_r;
  logic [AW-1:0]  s1_col_r, s1_colm;
  atkd_pkg::pos_t s1_f_r;

  logic           out_valid_r, out_valid_nxt;
  logic           out_on_r, out_end_r;

  logic           pend_v_r;
  logic [AW-1:0]  pend_a_r;
  logic [EW-1:0]  pend_d_r;
  logic [EW-1:0]  cn_r, can_r, diag_r;
  logic [EW-1:0]  cn_nxt, can_nxt, diag_nxt, pend_d_nxt;

  logic [EW-1:0]  rbc_q, rbm_q, tbc_q;
  logic [EW-1:0]  rbc_e, rbm_e, nb;
  logic [EW-1:0]  acc, pix_e;
  logic signed [EW-1:0] v_s, thr_s;
  logic           pix_on;
  logic [EW:0]    o_x;
  logic signed [EW:0] d_s, dn_s, err_full;
  logic [EW-1:0]  err;

  logic           rb_we, tb_we;
  logic [AW-1:0]  rb_wa;
  logic [EW-1:0]  rb_wd, tb_wd;

  atkd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  atkd_pos #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH),
    .AW             (AW)
  ) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_take),
    .cfg     (cfg),
    .col     (pos_col),
    .pos     (pos_f)
  );

  atkd_errmem #(
    .DEPTH (MAX_LINE_WIDTH),
    .AW    (AW),
    .EW    (EW)
  ) u_errmem (
    .clk       (clk),
    .rst_n     (rst_n),
    .busy      (busy),
    .rd_en     (in_take),
    .rd_addr   (pos_col),
    .rd_addr_m (pos_col - AW'(1)),
    .rb_we     (rb_we),
    .rb_wa     (rb_wa),
    .rb_wd     (rb_wd),
    .tb_we     (tb_we),
    .tb_wa     (s1_col_r),
    .tb_wd     (tb_wd),
    .rbc_q     (rbc_q),
    .rbm_q     (rbm_q),
    .tbc_q     (tbc_q)
  );

  assign go       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = busy || (s1_valid_r && out_valid_r && out_stall);
  assign in_take  = in_valid && !in_stall;
  assign s1_colm  = s1_col_r - AW'(1);

  always_comb begin
    rbc_e = (pend_v_r && pend_a_r == s1_col_r) ? pend_d_r : rbc_q;
    rbm_e = (pend_v_r && pend_a_r == s1_colm)  ? pend_d_r : rbm_q;

    pix_e  = {{(EW-8){s1_pix_r[7]}}, s1_pix_r};
    acc    = sat_add(rbc_e, cn_r);
    v_s    = sat_add(acc, pix_e);
    thr_s  = {{(EW-8){cfg.threshold[7]}}, cfg.threshold};
    pix_on = (v_s > thr_s);
    o_x    = pix_on ? {{(EW-6){1'b0}}, cfg.white_level} : '0;
    d_s    = {v_s[EW-1], v_s} - o_x;
    dn_s   = d_s + {{(EW-2){1'b0}}, {3{d_s[EW]}}};
    err_full = dn_s >>> atkd_pkg::ERR_SHIFT;
    err    = err_full[EW-1:0];

    nb = s1_f_r.first_col ? tbc_q : sat_add(tbc_q, diag_r);
    pend_d_nxt = s1_f_r.last_row ? '0 : sat_add(nb, err);
    tb_wd      = (!s1_f_r.last_row && s1_f_r.row_room) ? err : '0;
    tb_we      = go;

    cn_nxt   = s1_f_r.last_col ? '0 : sat_add(can_r, err);
    can_nxt  = (!s1_f_r.last_col && s1_f_r.col_room) ? err : '0;
    diag_nxt = (!s1_f_r.last_row && !s1_f_r.last_col) ? err : '0;

    // finish the column to the left, else drain the held entry
    priority if (go && !s1_f_r.first_col) begin
      rb_we = 1'b1;
      rb_wa = s1_colm;
      rb_wd = s1_f_r.last_row ? rbm_e : sat_add(rbm_e, err);
    end else if (pend_v_r && (go || !s1_valid_r)) begin
      rb_we = 1'b1;
      rb_wa = pend_a_r;
      rb_wd = pend_d_r;
    end else begin
      rb_we = 1'b0;
      rb_wa = pend_a_r;
      rb_wd = pend_d_r;
    end

    s1_valid_nxt  = in_take ? 1'b1 : (go ? 1'b0 : s1_valid_r);
    out_valid_nxt = go ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      cn_r        <= '0;
      can_r       <= '0;
      diag_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (go) begin
        pend_v_r <= 1'b1;
        cn_r     <= cn_nxt;
        can_r    <= can_nxt;
        diag_r   <= diag_nxt;
      end else if (!s1_valid_r) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pix_r <= in_pixel_value;
      s1_col_r <= pos_col;
      s1_f_r   <= pos_f;
    end
    if (go) begin
      pend_a_r  <= s1_col_r;
      pend_d_r  <= pend_d_nxt;
      out_on_r  <= pix_on;
      out_end_r <= s1_f_r.last_col && s1_f_r.last_row;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_on  = out_on_r;
  assign out_frame_end = out_end_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> in_stall)
    else $error("item accepted during memory clear");

  a_no_take_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !go) |-> !in_take)
    else $error("item accepted over a held compute stage");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && pos_f.last_col) |=> (pos_col == '0))
    else $error("column did not wrap after last column");

  a_idle_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && pend_v_r) |=> !pend_v_r)
    else $error("held row entry not drained while idle");

endmodule

// File: test/atkinson_error_diffusion_dither_top_test.sv
`timescale 1ns / 1ps

module atkinson_error_diffusion_dither_top_test;

  localparam int LINE_MAX = 512;
  localparam int ERROR_W  = 10;
  localparam int ERR_MAX  = (1 << (ERROR_W - 1)) - 1;
  localparam int ERR_MIN  = -ERR_MAX - 1;
  localparam int ERR_DIV  = 8;
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    logic pixel_on;
    logic frame_end;
  } dither_out_t;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic signed [7:0]                in_pixel_value;
  logic                             out_valid;
  logic                             out_stall;
  logic                             out_pixel_on;
  logic                             out_frame_end;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [atkd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [atkd_pkg::CFG_DATA_W-1:0]  cfg_data;

  logic signed [7:0] pixel_queue[$];
  dither_out_t       dither_expected[$];
  logic              in_took;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_seq;
  int                hold_seen;
  int                hold_left;
  int                errors;

  // predictor configuration and state
  logic signed [7:0]         thr_cfg;
  logic [6:0]                white_cfg;
  logic [9:0]                lw_cfg;
  logic [10:0]               rows_cfg;
  logic signed [ERROR_W-1:0] err_carry1;
  logic signed [ERROR_W-1:0] err_carry2;
  logic signed [ERROR_W-1:0] err_row1[LINE_MAX];
  logic signed [ERROR_W-1:0] err_row2[LINE_MAX];
  logic signed [ERROR_W-1:0] diag_err;
  int                        col_pos;
  int                        row_pos;

  atkinson_error_diffusion_dither_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_on   (out_pixel_on),
    .out_frame_end  (out_frame_end),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sat_err(int a, int b);
    int s;
    s = a + b;
    if (s > ERR_MAX) return ERR_MAX;
    if (s < ERR_MIN) return ERR_MIN;
    return s;
  endfunction

  function automatic dither_out_t dither_pixel(logic signed [7:0] pix);
    int w, h, c, r, acc, v, o, err, nb;
    logic last_col, last_row, on;
    dither_out_t res;
    w = int'(lw_cfg);
    h = int'(rows_cfg);
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    if (h < 1) h = 1;
    if (h > int'(atkd_pkg::MAX_FRAME_ROWS)) h = int'(atkd_pkg::MAX_FRAME_ROWS);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    last_col = (c + 1 >= w);
    last_row = (r + 1 >= h);

    acc = sat_err(err_row1[c], err_carry1);
    v   = sat_err(acc, int'(pix));
    on  = (v > int'(thr_cfg));
    o   = on ? int'(white_cfg) : 0;
    err = (v - o) / ERR_DIV;

    if (last_col) begin
      err_carry1 = '0;
      err_carry2 = '0;
    end else begin
      err_carry1 = ERROR_W'(sat_err(err_carry2, err));
      err_carry2 = (c + 2 < w) ? ERROR_W'(err) : '0;
    end

    if (!last_row) begin
      nb = err_row2[c];
      if (c > 0) begin
        err_row1[c-1] = ERROR_W'(sat_err(err_row1[c-1], err));
        nb = sat_err(nb, diag_err);
      end
      err_row1[c] = ERROR_W'(sat_err(nb, err));
      err_row2[c] = (r + 2 < h) ? ERROR_W'(err) : '0;
      diag_err    = last_col ? '0 : ERROR_W'(err);
    end else begin
      err_row1[c] = '0;
      err_row2[c] = '0;
      diag_err    = '0;
    end

    res.pixel_on  = on;
    res.frame_end = last_col && last_row;

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return res;
  endfunction

  // accept items, predict, and check results
  always @(posedge clk) begin
    dither_out_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      dither_expected.push_back(dither_pixel(in_pixel_value));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (dither_expected.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected result: pixel_on=%0b frame_end=%0b", out_pixel_on, out_frame_end);
        end
        errors++;
      end else begin
        want = dither_expected.pop_front();
        if (want.pixel_on !== out_pixel_on || want.frame_end !== out_frame_end) begin
          if (errors < 10) begin
            $display("mismatch: pixel_on exp %0b got %0b, frame_end exp %0b got %0b",
                     want.pixel_on, out_pixel_on, want.frame_end, out_frame_end);
          end
          errors++;
        end
      end
    end
  end

  // offer items; hold a stalled item
  always @(negedge clk) begin
    if (!in_valid || in_took) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid       <= 1'b1;
        in_pixel_value <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(atkd_pkg::cfg_reg_t idx, logic [10:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      atkd_pkg::CFG_THRESHOLD:   thr_cfg   = data[7:0];
      atkd_pkg::CFG_WHITE_LEVEL: white_cfg = data[6:0];
      atkd_pkg::CFG_LINE_WIDTH:  lw_cfg    = data[9:0];
      atkd_pkg::CFG_FRAME_ROWS:  rows_cfg  = data[10:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [10:0] thr, logic [10:0] white, logic [10:0] lw,
                           logic [10:0] rows);
    write_reg(atkd_pkg::CFG_THRESHOLD, thr);
    write_reg(atkd_pkg::CFG_WHITE_LEVEL, white);
    write_reg(atkd_pkg::CFG_LINE_WIDTH, lw);
    write_reg(atkd_pkg::CFG_FRAME_ROWS, rows);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pixel_queue.size() != 0 || in_valid || dither_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int chunk, left, run, kind, i, t, n;
    logic [10:0] thr_w, white_w, lw_w, rows_w;
    logic [7:0] base;
    logic signed [7:0] px;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel_value = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_took        = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    hold_seq       = 0;
    hold_seen      = 0;
    hold_left      = 0;
    errors         = 0;

    thr_cfg    = atkd_pkg::THRESHOLD_RST;
    white_cfg  = atkd_pkg::WHITE_LEVEL_RST;
    lw_cfg     = atkd_pkg::LINE_WIDTH_RST;
    rows_cfg   = atkd_pkg::FRAME_ROWS_RST;
    err_carry1 = '0;
    err_carry2 = '0;
    diag_err   = '0;
    col_pos    = 0;
    row_pos    = 0;
    foreach (err_row1[k]) begin
      err_row1[k] = '0;
      err_row2[k] = '0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: extremes and threshold boundary
    pixel_queue = '{8'sd0, 8'sd127, -8'sd128, 8'sd64, 8'sd65, -8'sd1};
    wait_idle();

    // narrow the frame mid-row, run through to its end
    configure(11'd64, 11'd127, 11'd3, 11'd3);
    pixel_queue = '{8'sd127, -8'sd128, 8'sd100, 8'sd10, 8'sd127, 8'sd0, -8'sd50};
    wait_idle();

    // zero sizes: every item closes a frame
    configure(11'd0, 11'd64, 11'd0, 11'd0);
    pixel_queue = '{8'sd1, 8'sd0, -8'sd1};
    wait_idle();

    // oversized frame, extreme threshold and white level
    configure(11'h780, 11'd0, 11'd1023, 11'd2047);
    pixel_queue = '{-8'sd128, -8'sd128, 8'sd127, -8'sd127};
    wait_idle();

    for (chunk = 0; chunk < 10; chunk++) begin
      send_idle_pct = (chunk < 4) ? 29 : (chunk < 7) ? 75 : 0;
      recv_idle_pct = (chunk < 4) ? 75 : (chunk < 7) ? 29 : 0;

      case ($urandom_range(3))
        0:       thr_w = {3'($urandom_range(7)), 8'h80};
        1:       thr_w = {3'($urandom_range(7)), 8'h7f};
        2:       thr_w = 11'd64;
        default: thr_w = 11'($urandom_range(2047));
      endcase
      case ($urandom_range(2))
        0:       white_w = 11'd0;
        1:       white_w = 11'd127;
        default: white_w = 11'($urandom_range(2047));
      endcase
      case ($urandom_range(9))
        0:       lw_w = 11'($urandom_range(2));
        1:       lw_w = ($urandom_range(1) != 0) ? 11'd512 : 11'($urandom_range(2047));
        default: lw_w = 11'($urandom_range(12, 3));
      endcase
      case ($urandom_range(9))
        0:       rows_w = 11'($urandom_range(2));
        1:       rows_w = ($urandom_range(1) != 0) ? 11'd1024 : 11'd2047;
        default: rows_w = 11'($urandom_range(6, 3));
      endcase
      configure(thr_w, white_w, lw_w, rows_w);

      left = $urandom_range(190, 120);
      while (left > 0) begin
        run  = $urandom_range(16, 1);
        if (run > left) run = left;
        kind = $urandom_range(3);
        base = ($urandom_range(1) != 0) ? 8'h7f : 8'h80;
        if (kind == 3) base = 8'($urandom_range(255));
        for (i = 0; i < run; i++) begin
          case (kind)
            0: px = 8'($urandom_range(255));
            2: begin
              t = int'($urandom_range(16));
              t = t + int'(thr_cfg) - 8;
              if (t > 127) t = 127;
              if (t < -128) t = -128;
              px = 8'(t);
            end
            default: px = base;
          endcase
          pixel_queue.push_back(px);
        end
        left -= run;
      end

      if (chunk == 1 || chunk == 5) hold_seq++;
      wait_idle();
    end

    n = 0;
    while (n < 10) begin
      @(posedge clk);
      n++;
    end
    if (dither_expected.size() != 0) errors++;

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
